// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the checker files
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// antecedent implies consequent in the same cycle
`define ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== rtl/core/sbps_pkg.sv =====
// shared types and constants of the sprite billboard pixel shader
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package sbps_pkg;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 14;
    localparam int POS_W  = 10;
    localparam int CMD_W  = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_WRITE_TEXEL = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE_DEPTH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RENDER      = 2'd2;

    // register indexes
    localparam logic [2:0] REG_WIDTH    = 3'd0;
    localparam logic [2:0] REG_HEIGHT   = 3'd1;
    localparam logic [2:0] REG_CENTER_X = 3'd2;
    localparam logic [2:0] REG_DEPTH    = 3'd3;
    localparam logic [2:0] REG_FRAME    = 3'd4;

    localparam logic [23:0] COLOR_MASK = 24'hFF_FFFF;

    // word travelling alongside the dividers
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wval;
        logic [POS_W-1:0]  col;
        logic [POS_W-1:0]  row;
        logic              bad;
        logic              neg_x;
        logic              neg_y;
    } side_t;
endpackage
`default_nettype wire

// ===== rtl/core/sbps_if.sv =====
// valid/ready channel interfaces for command and pixel words
// uses sbps_pkg
`timescale 1ns / 1ps
`default_nettype none
interface sbps_in_if;
    logic                         valid;
    logic                         ready;
    logic [sbps_pkg::CMD_W-1:0]   cmd;
    logic [sbps_pkg::ADDR_W-1:0]  texel_address;
    logic [sbps_pkg::DATA_W-1:0]  write_value;
    logic [sbps_pkg::POS_W-1:0]   column;
    logic [sbps_pkg::POS_W-1:0]   row;
    modport source (output valid, cmd, texel_address, write_value, column, row, input ready);
    modport sink (input valid, cmd, texel_address, write_value, column, row, output ready);
endinterface

interface sbps_out_if;
    logic                        valid;
    logic                        ready;
    logic [sbps_pkg::POS_W-1:0]  pixel_column;
    logic [sbps_pkg::POS_W-1:0]  pixel_row;
    logic [sbps_pkg::DATA_W-1:0] pixel_color;
    modport source (output valid, pixel_column, pixel_row, pixel_color, input ready);
    modport sink (input valid, pixel_column, pixel_row, pixel_color, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/sbps_div.sv =====
// pipelined restoring divider, one quotient bit per stage, with range flag
// uses sbps_pkg
`timescale 1ns / 1ps
`default_nettype none
module sbps_div #(
    parameter int QB    = 6,
    parameter int LIMIT = 64
) (
    input  wire logic                        clk,
    input  wire logic                        en,
    input  wire logic [sbps_pkg::DATA_W-1:0] num,
    input  wire logic [sbps_pkg::DATA_W-1:0] den,
    output logic [QB-1:0]                    quo,
    output logic                             in_range
);
    localparam int NW = sbps_pkg::DATA_W;

    logic [NW-1:0] rem_reg [0:QB-1];
    logic [NW-1:0] den_reg [0:QB-1];
    logic [QB-1:0] q_reg   [0:QB];
    logic          ok_reg  [0:QB];
    logic [NW-1:0] trial   [0:QB-1];
    logic          ge      [0:QB-1];
    logic [NW-1:0] limit_val;

    // quotient fits only if num < den * limit
    assign limit_val = NW'(den * LIMIT);

    // trial subtract for each stage
    always_comb
    begin
        for (int j = 0; j < QB; j++)
        begin
            trial[j] = den_reg[j] << (QB - 1 - j);
            ge[j]    = rem_reg[j] >= trial[j];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num;
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            ok_reg[0]  <= num < limit_val;
            for (int j = 0; j < QB; j++)
            begin
                q_reg[j+1]  <= q_reg[j] | (QB'(ge[j]) << (QB - 1 - j));
                ok_reg[j+1] <= ok_reg[j];
                if (j < QB - 1)
                begin
                    rem_reg[j+1] <= ge[j] ? rem_reg[j] - trial[j] : rem_reg[j];
                    den_reg[j+1] <= den_reg[j];
                end
            end
        end
    end

    assign quo      = q_reg[QB];
    assign in_range = ok_reg[QB];
endmodule
`default_nettype wire

// ===== rtl/core/sprite_billboard_pixel_shader_top.sv =====
// Billboard sprite pixel shader: one command per cycle sustained while the output
// is not stalled. An accepted command passes input capture, the two one-bit-per-stage
// dividers, the registered texture and depth memory reads and the output register.
// A stalled output stalls the whole pipeline.
// Reset clears valid bits and configuration registers; memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module sprite_billboard_pixel_shader_top #(
    parameter int TEXTURE_SIZE  = 64,
    parameter int FRAME_COUNT   = 4,
    parameter int SCREEN_HEIGHT = 1024,
    parameter int SCREEN_WIDTH  = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    sbps_in_if.sink          pix_in,
    sbps_out_if.source       pix_out
);
    localparam int QB    = $clog2(TEXTURE_SIZE);
    localparam int TPF   = TEXTURE_SIZE * TEXTURE_SIZE;
    localparam int TCNT  = FRAME_COUNT * TPF;
    localparam int TIW   = $clog2(TCNT);
    localparam int DIW   = $clog2(SCREEN_WIDTH);
    localparam int SH_OF = SCREEN_HEIGHT * 128;
    localparam int DW    = sbps_pkg::DATA_W;

    // configuration registers
    logic [11:0]        cfg_w_reg, cfg_h_reg;
    logic signed [15:0] cfg_cx_reg;
    logic signed [31:0] cfg_depth_reg;
    logic [1:0]         cfg_frame_reg;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_w_reg     <= 12'd1;
            cfg_h_reg     <= 12'd1;
            cfg_cx_reg    <= '0;
            cfg_depth_reg <= '0;
            cfg_frame_reg <= '0;
        end
        else if (wr_en)
        begin
            case (paddr[4:2])
                sbps_pkg::REG_WIDTH:    cfg_w_reg     <= pwdata[11:0];
                sbps_pkg::REG_HEIGHT:   cfg_h_reg     <= pwdata[11:0];
                sbps_pkg::REG_CENTER_X: cfg_cx_reg    <= pwdata[15:0];
                sbps_pkg::REG_DEPTH:    cfg_depth_reg <= pwdata;
                sbps_pkg::REG_FRAME:    cfg_frame_reg <= pwdata[1:0];
                default:                ;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        case (paddr[4:2])
            sbps_pkg::REG_WIDTH:    prdata = 32'(cfg_w_reg);
            sbps_pkg::REG_HEIGHT:   prdata = 32'(cfg_h_reg);
            sbps_pkg::REG_CENTER_X: prdata = {16'b0, cfg_cx_reg};
            sbps_pkg::REG_DEPTH:    prdata = cfg_depth_reg;
            sbps_pkg::REG_FRAME:    prdata = 32'(cfg_frame_reg);
            default:                prdata = '0;
        endcase
    end

    // global advance: move when the output slot is free or being taken
    logic out_valid_reg;
    logic adv;
    assign adv          = !out_valid_reg || pix_out.ready;
    assign pix_in.ready = adv;

    // stage a: input capture
    logic                          a_valid_reg;
    logic [sbps_pkg::CMD_W-1:0]    a_cmd_reg;
    logic [sbps_pkg::ADDR_W-1:0]   a_addr_reg;
    logic [DW-1:0]                 a_wval_reg;
    logic [sbps_pkg::POS_W-1:0]    a_col_reg, a_row_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (adv)
            a_valid_reg <= pix_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_cmd_reg  <= pix_in.cmd;
            a_addr_reg <= pix_in.texel_address;
            a_wval_reg <= pix_in.write_value;
            a_col_reg  <= pix_in.column;
            a_row_reg  <= pix_in.row;
        end
    end

    // texture coordinate numerators and divisors
    logic signed [31:0] base_s, raw_s;
    logic [31:0]        abs_x, abs_y, num_x, num_y, den_x, den_y;
    logic [31:0]        col_ext;
    logic               a_bad;
    sbps_pkg::side_t    a_side;

    always_comb
    begin
        base_s = signed'(32'(a_col_reg)) + signed'(32'(cfg_w_reg[11:1])) - 32'(cfg_cx_reg);
        raw_s  = signed'(32'({a_row_reg, 8'b0})) - 32'(SH_OF)
                 + signed'(32'({cfg_h_reg, 7'b0}));
        abs_x  = base_s[31] ? 32'(-base_s) : 32'(base_s);
        abs_y  = raw_s[31] ? 32'(-raw_s) : 32'(raw_s);
        num_x  = 32'(abs_x * TEXTURE_SIZE);
        num_y  = 32'(abs_y * TEXTURE_SIZE);
        den_x  = 32'(cfg_w_reg);
        den_y  = 32'({cfg_h_reg, 8'b0});
        col_ext = 32'(a_col_reg);
        a_bad  = (cfg_w_reg == '0) || (cfg_h_reg == '0)
                 || (32'(cfg_frame_reg) >= 32'(FRAME_COUNT))
                 || (col_ext >= 32'(SCREEN_WIDTH));
        a_side = '{cmd: a_cmd_reg, addr: a_addr_reg, wval: a_wval_reg, col: a_col_reg,
                   row: a_row_reg, bad: a_bad, neg_x: base_s[31], neg_y: raw_s[31]};
    end

    // dividers
    logic [QB-1:0] q_x, q_y;
    logic          ok_x, ok_y;

    sbps_div #(.QB(QB), .LIMIT(TEXTURE_SIZE)) u_div_x (
        .clk(clk), .en(adv), .num(num_x), .den(den_x), .quo(q_x), .in_range(ok_x)
    );
    sbps_div #(.QB(QB), .LIMIT(TEXTURE_SIZE)) u_div_y (
        .clk(clk), .en(adv), .num(num_y), .den(den_y), .quo(q_y), .in_range(ok_y)
    );

    // side words matching the divider depth
    logic            p_valid_reg [0:QB];
    sbps_pkg::side_t p_side_reg  [0:QB];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j <= QB; j++)
                p_valid_reg[j] <= 1'b0;
        end
        else if (adv)
        begin
            p_valid_reg[0] <= a_valid_reg;
            for (int j = 1; j <= QB; j++)
                p_valid_reg[j] <= p_valid_reg[j-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_side_reg[0] <= a_side;
            for (int j = 1; j <= QB; j++)
                p_side_reg[j] <= p_side_reg[j-1];
        end
    end

    // texel index and memory addresses
    sbps_pkg::side_t s;
    logic            tx_ok, ty_ok, render_ok, taddr_ok, dcol_ok;
    logic [31:0]     rd_idx32, wr_idx32, col32;
    logic [TIW-1:0]  tex_idx;
    logic [DIW-1:0]  dep_idx;

    always_comb
    begin
        s         = p_side_reg[QB];
        tx_ok     = ok_x && ((q_x == '0) || !s.neg_x);
        ty_ok     = ok_y && ((q_y == '0) || !s.neg_y);
        render_ok = (s.cmd == sbps_pkg::CMD_RENDER) && !s.bad && tx_ok && ty_ok;
        rd_idx32  = 32'(32'(cfg_frame_reg) * TPF) + 32'(32'(q_y) * TEXTURE_SIZE) + 32'(q_x);
        wr_idx32  = 32'(s.addr);
        col32     = 32'(s.col);
        taddr_ok  = wr_idx32 < 32'(TCNT);
        dcol_ok   = col32 < 32'(SCREEN_WIDTH);
        tex_idx   = (s.cmd == sbps_pkg::CMD_WRITE_TEXEL) ? wr_idx32[TIW-1:0] : rd_idx32[TIW-1:0];
        dep_idx   = col32[DIW-1:0];
    end

    // texture memory
    logic [DW-1:0] tex_mem [0:TCNT-1];
    logic [DW-1:0] tex_rd_reg;

    always_ff @(posedge clk)
    begin
        if (adv && p_valid_reg[QB])
        begin
            if (s.cmd == sbps_pkg::CMD_WRITE_TEXEL && taddr_ok)
                tex_mem[tex_idx] <= s.wval;
            else if (render_ok)
                tex_rd_reg <= tex_mem[tex_idx];
        end
    end

    // column depth memory
    logic [DW-1:0] dep_mem [0:SCREEN_WIDTH-1];
    logic [DW-1:0] dep_rd_reg;

    always_ff @(posedge clk)
    begin
        if (adv && p_valid_reg[QB])
        begin
            if (s.cmd == sbps_pkg::CMD_WRITE_DEPTH && dcol_ok)
                dep_mem[dep_idx] <= s.wval;
            else if (render_ok)
                dep_rd_reg <= dep_mem[dep_idx];
        end
    end

    // stage d: alongside the memory read data
    logic                       d_draw_reg;
    logic [sbps_pkg::POS_W-1:0] d_col_reg, d_row_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_draw_reg <= 1'b0;
        else if (adv)
            d_draw_reg <= p_valid_reg[QB] && render_ok;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_col_reg <= s.col;
            d_row_reg <= s.row;
        end
    end

    // transparency and depth test, output register
    logic draw_next;
    assign draw_next = d_draw_reg && (tex_rd_reg[23:0] & sbps_pkg::COLOR_MASK) != '0
                       && !cfg_depth_reg[31] && cfg_depth_reg != '0
                       && unsigned'(cfg_depth_reg) < dep_rd_reg;

    logic [sbps_pkg::POS_W-1:0] out_col_reg, out_row_reg;
    logic [DW-1:0]              out_color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= draw_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_col_reg   <= d_col_reg;
            out_row_reg   <= d_row_reg;
            out_color_reg <= tex_rd_reg;
        end
    end

    assign pix_out.valid        = out_valid_reg;
    assign pix_out.pixel_column = out_col_reg;
    assign pix_out.pixel_row    = out_row_reg;
    assign pix_out.pixel_color  = out_color_reg;
endmodule
`default_nettype wire

// ===== rtl/core/sbps_checker.sv =====
// port-level checks of the pixel shader, bound to the top level
// uses assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sbps_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [9:0]  out_col,
    input wire logic [9:0]  out_row,
    input wire logic [31:0] out_color
);
    // a stalled pixel word holds
    `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable({out_col, out_row, out_color}))
    // input is back-pressured only by a stalled output
    `ASSERT_SAME(a_ready_rule, 1'b1, in_ready == (!out_valid || out_ready))
    // a new pixel word appears only after the pipeline moved
    `ASSERT_SAME(a_rise_moved, $rose(out_valid), $past(in_ready))
    // a stall stops intake
    `ASSERT_SAME(a_stall_block, out_valid && !out_ready, !in_ready)
endmodule

bind sprite_billboard_pixel_shader_top sbps_checker u_sbps_checker (
    .clk(clk), .rst_n(rst_n),
    .in_ready(pix_in.ready),
    .out_valid(pix_out.valid), .out_ready(pix_out.ready),
    .out_col(pix_out.pixel_column), .out_row(pix_out.pixel_row),
    .out_color(pix_out.pixel_color)
);
`default_nettype wire

// ===== sim/sbps_pixel_checker.sv =====
// checker for the sprite billboard pixel shader: mirrors the texture, depth and register state
// and predicts each shaded pixel word. Depends on sbps_pkg and the channel interfaces in sbps_if.
`timescale 1ns / 1ps
module sbps_pixel_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    sbps_in_if          cmd_ch,
    sbps_out_if         pix_ch,
    output int          mismatches,
    output int          pending
);
    localparam int TEX_DIM    = 64;
    localparam int FRAMES     = 4;
    localparam int SCR_HEIGHT = 1024;

    typedef struct {
        logic [sbps_pkg::POS_W-1:0]  col;
        logic [sbps_pkg::POS_W-1:0]  row;
        logic [sbps_pkg::DATA_W-1:0] color;
    } pixel_t;

    logic [31:0] texels [FRAMES*TEX_DIM*TEX_DIM];
    logic [31:0] col_depths [1024];

    logic [11:0] width_q;
    logic [11:0] height_q;
    int          center_x_q;
    int          depth_q;
    logic [1:0]  frame_q;

    pixel_t drawn_q[$];

    // shade one pixel; returns 1 when a pixel word is due
    function automatic bit shade_pixel(input logic [sbps_pkg::POS_W-1:0] col,
                                       input logic [sbps_pkg::POS_W-1:0] row,
                                       output logic [31:0] color);
        longint w;
        longint h;
        longint base;
        longint raw;
        longint tx;
        longint ty;
        w = longint'(width_q);
        h = longint'(height_q);
        color = '0;
        if (w == 0 || h == 0)
            return 0;
        if (int'(frame_q) >= FRAMES)
            return 0;
        base = longint'(col) - (-(w / 2) + longint'(center_x_q));
        tx = 256 * base * TEX_DIM / w / 256;
        raw = longint'(row) * 256 - SCR_HEIGHT * 128 + h * 128;
        ty = raw * TEX_DIM / h / 256;
        if (ty < 0 || ty >= TEX_DIM || tx < 0 || tx >= TEX_DIM)
            return 0;
        color = texels[int'(frame_q) * TEX_DIM * TEX_DIM + int'(ty) * TEX_DIM + int'(tx)];
        if ((color[23:0] & sbps_pkg::COLOR_MASK) == 24'h0)
            return 0;
        if (!(depth_q > 0 && unsigned'(depth_q) < col_depths[col]))
            return 0;
        return 1;
    endfunction

    always @(posedge clk)
    begin
        pixel_t      got;
        pixel_t      want;
        logic [31:0] color;
        if (!rst_n)
        begin
            width_q    = 12'd1;
            height_q   = 12'd1;
            center_x_q = 0;
            depth_q    = 0;
            frame_q    = 2'd0;
            drawn_q.delete();
            mismatches <= 0;
        end
        else
        begin
            // register writes seen on the config port
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    sbps_pkg::REG_WIDTH:    width_q = pwdata[11:0];
                    sbps_pkg::REG_HEIGHT:   height_q = pwdata[11:0];
                    sbps_pkg::REG_CENTER_X: center_x_q = int'(signed'(pwdata[15:0]));
                    sbps_pkg::REG_DEPTH:    depth_q = int'(signed'(pwdata));
                    sbps_pkg::REG_FRAME:    frame_q = pwdata[1:0];
                    default: ;
                endcase
            end
            // compare a pixel word against the oldest prediction
            if (pix_ch.valid && pix_ch.ready)
            begin
                got.col   = pix_ch.pixel_column;
                got.row   = pix_ch.pixel_row;
                got.color = pix_ch.pixel_color;
                if (drawn_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected pixel word col %0d row %0d color %h",
                                 got.col, got.row, got.color);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = drawn_q.pop_front();
                    if (got.col !== want.col || got.row !== want.row
                        || got.color !== want.color)
                    begin
                        if (mismatches < 10)
                            $display("pixel mismatch: expected %0d/%0d/%h got %0d/%0d/%h",
                                     want.col, want.row, want.color,
                                     got.col, got.row, got.color);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            // update the stores or predict a pixel for each command word
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                case (cmd_ch.cmd)
                    sbps_pkg::CMD_WRITE_TEXEL:
                        texels[cmd_ch.texel_address] = cmd_ch.write_value;
                    sbps_pkg::CMD_WRITE_DEPTH:
                        col_depths[cmd_ch.column] = cmd_ch.write_value;
                    sbps_pkg::CMD_RENDER:
                    begin
                        if (shade_pixel(cmd_ch.column, cmd_ch.row, color))
                        begin
                            want.col   = cmd_ch.column;
                            want.row   = cmd_ch.row;
                            want.color = color;
                            drawn_q.push_back(want);
                        end
                    end
                    default: ;
                endcase
            end
        end
        pending <= drawn_q.size();
    end
endmodule

// ===== sim/sprite_billboard_pixel_shader_top_tb.sv =====
// testbench top for the sprite billboard pixel shader: drives command words and register
// writes under several idling patterns. Depends on sbps_pkg, sbps_if and sbps_pixel_checker.
`timescale 1ns / 1ps
module sprite_billboard_pixel_shader_top_tb;
    localparam int LATENCY     = 10;
    localparam int CYCLE_LIMIT = 600000;
    localparam int TEX_SIDE    = 64;
    localparam int SCREEN_ROWS = 1024;

    // command code the block ignores
    localparam logic [sbps_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          mismatches;
    int          pending;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          cur_width;
    int          cur_height;
    int          cur_center;
    int          cur_frame;

    // which store entries have been loaded so far
    bit          tex_written [16384];
    bit          dep_written [1024];

    sbps_in_if  cmd_ch();
    sbps_out_if pix_ch();

    sprite_billboard_pixel_shader_top uut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .pix_in(cmd_ch), .pix_out(pix_ch)
    );

    sbps_pixel_checker u_checker (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .pready(pready),
        .cmd_ch(cmd_ch), .pix_ch(pix_ch), .mismatches(mismatches), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // receiver stalls
    always @(posedge clk)
        pix_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

    // watchdog
    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("[sprite_billboard_pixel_shader_top] ERROR");
        $finish;
    end

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // sender pauses until every pixel word is back and the pipeline has drained
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic set_sprite(input int w, input int h, input int cx, input int dep,
                              input int frm);
        drain();
        cur_width  = w;
        cur_height = h;
        cur_center = cx;
        cur_frame  = frm;
        reg_write(sbps_pkg::REG_WIDTH, w);
        reg_write(sbps_pkg::REG_HEIGHT, h);
        reg_write(sbps_pkg::REG_CENTER_X, cx);
        reg_write(sbps_pkg::REG_DEPTH, dep);
        reg_write(sbps_pkg::REG_FRAME, frm);
    endtask

    function automatic logic [31:0] rand_texel();
        logic [31:0] v;
        v = $urandom;
        if ($urandom_range(3) == 0)
            v[23:0] = '0;
        return v;
    endfunction

    // texel a render word reads under the current sprite, or -1 when it reads none
    function automatic int texel_index(input int c, input int r);
        longint w;
        longint h;
        longint base;
        longint raw;
        longint tx;
        longint ty;
        w = longint'(cur_width);
        h = longint'(cur_height);
        if (w == 0 || h == 0 || cur_frame >= 4)
            return -1;
        base = longint'(c) - (-(w / 2) + longint'(cur_center));
        tx = 256 * base * TEX_SIDE / w / 256;
        raw = longint'(r) * 256 - SCREEN_ROWS * 128 + h * 128;
        ty = raw * TEX_SIDE / h / 256;
        if (ty < 0 || ty >= TEX_SIDE || tx < 0 || tx >= TEX_SIDE)
            return -1;
        return cur_frame * TEX_SIDE * TEX_SIDE + int'(ty) * TEX_SIDE + int'(tx);
    endfunction

    task automatic send_word(input logic [sbps_pkg::CMD_W-1:0] cmd, input logic [13:0] addr,
                             input logic [31:0] value, input logic [9:0] col,
                             input logic [9:0] row);
        int idx;
        // load the texel and column depth a render reads before it goes out
        if (cmd == sbps_pkg::CMD_RENDER)
        begin
            idx = texel_index(int'(col), int'(row));
            if (idx >= 0 && !tex_written[idx])
                send_word(sbps_pkg::CMD_WRITE_TEXEL, 14'(idx), rand_texel(), col, row);
            if (idx >= 0 && !dep_written[col])
                send_word(sbps_pkg::CMD_WRITE_DEPTH, addr, $urandom, col, row);
        end
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid         <= 1'b1;
        cmd_ch.cmd           <= cmd;
        cmd_ch.texel_address <= addr;
        cmd_ch.write_value   <= value;
        cmd_ch.column        <= col;
        cmd_ch.row           <= row;
        @(negedge clk);
        while (!cmd_ch.ready)
            @(negedge clk);
        @(posedge clk);
        if (cmd == sbps_pkg::CMD_WRITE_TEXEL)
            tex_written[addr] = 1'b1;
        else if (cmd == sbps_pkg::CMD_WRITE_DEPTH)
            dep_written[col] = 1'b1;
    endtask

    // render word aimed mostly at the sprite rectangle
    task automatic send_render();
        int c;
        int r;
        if ($urandom_range(99) < 75)
        begin
            c = cur_center + $urandom_range(cur_width + 4) - cur_width / 2 - 2;
            r = 512 + $urandom_range(cur_height + 4) - cur_height / 2 - 2;
            c = (c < 0) ? 0 : (c > 1023) ? 1023 : c;
            r = (r < 0) ? 0 : (r > 1023) ? 1023 : r;
        end
        else
        begin
            c = $urandom_range(1023);
            r = $urandom_range(1023);
        end
        send_word(sbps_pkg::CMD_RENDER, $urandom, $urandom, c, r);
    endtask

    initial
    begin
        int dep;
        int w;
        int h;
        int cx;
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        cmd_ch.valid   = 1'b0;
        cmd_ch.cmd     = sbps_pkg::CMD_WRITE_TEXEL;
        cmd_ch.texel_address = '0;
        cmd_ch.write_value   = '0;
        cmd_ch.column  = '0;
        cmd_ch.row     = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        cur_width      = 1;
        cur_height     = 1;
        cur_center     = 0;
        cur_frame      = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset registers, corners, each frame, depth limits, unused command
        send_word(sbps_pkg::CMD_RENDER, 14'h3FFF, 32'hFFFF_FFFF, 10'd0, 10'd512);
        send_word(sbps_pkg::CMD_RENDER, 14'h0, 32'h0, 10'd1023, 10'd1023);
        send_word(sbps_pkg::CMD_RENDER, 14'h0, 32'h0, 10'd0, 10'd0);
        send_word(CMD_UNUSED, 14'h3FFF, 32'hFFFF_FFFF, 10'd1023, 10'd1023);
        for (int f = 0; f < 4; f++)
        begin
            set_sprite(64, 64, 512, 32'h0000_0100, f);
            send_word(sbps_pkg::CMD_RENDER, 0, 0, 10'd480, 10'd480);
            send_word(sbps_pkg::CMD_RENDER, 0, 0, 10'd543, 10'd543);
            send_word(sbps_pkg::CMD_RENDER, 0, 0, 10'd512, 10'd512);
        end
        set_sprite(64, 64, 512, 32'hFFFF_0000, 0);
        send_word(sbps_pkg::CMD_RENDER, 0, 0, 10'd500, 10'd500);
        set_sprite(64, 64, 512, 32'h7FFF_FFFF, 1);
        send_word(sbps_pkg::CMD_RENDER, 0, 0, 10'd500, 10'd500);
        set_sprite(4095, 4095, -32768, 32'h0000_0001, 2);
        send_word(sbps_pkg::CMD_RENDER, 0, 0, 10'd1023, 10'd0);
        set_sprite(4095, 4095, 32767, 32'h0000_0001, 3);
        send_word(sbps_pkg::CMD_RENDER, 0, 0, 10'd0, 10'd1023);

        // random phases: free flow, sender idle, receiver stalls, both
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = (p == 1) ? 75 : (p == 3) ? 32 : 0;
            recv_stall_pct = (p == 2) ? 75 : (p == 3) ? 32 : 0;
            for (int k = 0; k < 4; k++)
            begin
                case ($urandom_range(5))
                    0: w = 1;
                    1: w = 4095;
                    default: w = $urandom_range(2, 200);
                endcase
                h = ($urandom_range(5) == 0) ? (($urandom_range(1) == 0) ? 1 : 4095)
                                             : $urandom_range(2, 200);
                cx = ($urandom_range(7) == 0) ? int'(signed'(16'($urandom)))
                                              : $urandom_range(1023);
                case ($urandom_range(7))
                    0: dep = 0;
                    1: dep = -int'($urandom_range(65536));
                    2: dep = 32'h7FFF_FFFF;
                    default: dep = $urandom;
                endcase
                set_sprite(w, h, cx, dep, $urandom_range(3));
                for (int n = 0; n < 20; n++)
                begin
                    case ($urandom_range(19))
                        0: send_word(sbps_pkg::CMD_WRITE_TEXEL, $urandom, rand_texel(),
                                     $urandom, $urandom);
                        1: send_word(sbps_pkg::CMD_WRITE_DEPTH, $urandom, $urandom, $urandom,
                                     $urandom);
                        2: send_word(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom);
                        default: send_render();
                    endcase
                end
            end
        end

        drain();
        repeat (2 * LATENCY) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("[sprite_billboard_pixel_shader_top] OK");
        else
            $display("[sprite_billboard_pixel_shader_top] ERROR");
        $finish;
    end
endmodule
